// File: sv/agc_pkg.sv
package agc_pkg;

  localparam int SampleWidth  = 16;
  localparam int MagWidth     = SampleWidth + 4;
  localparam int ProdWidth    = SampleWidth + 5;
  localparam int GainWidth    = 20;
  localparam int PowWidth     = 32;
  localparam int CoefWidth    = 16;
  localparam int GstepWidth   = 17;
  localparam int ThrWidth     = 15;
  localparam int MulAWidth    = PowWidth + 1;
  localparam int MulBWidth    = ((MagWidth > GstepWidth) ? MagWidth : GstepWidth) + 1;
  localparam int AccWidth     = 64;
  localparam int DataWidth    = 32;
  localparam int RegIdxWidth  = 3;
  localparam int AddrWidth    = RegIdxWidth + 2;
  localparam int StepCntWidth = 4;

  localparam logic [CoefWidth-1:0]  AttackReset   = 16'd64722;
  localparam logic [CoefWidth-1:0]  ReleaseReset  = 16'd65509;
  localparam logic [PowWidth-1:0]   TargetReset   = 32'd26843546;
  localparam logic [PowWidth-1:0]   SilenceReset  = 32'd2684355;
  localparam logic [GstepWidth-1:0] IncreaseReset = 17'd67372;
  localparam logic [CoefWidth-1:0]  DecreaseReset = 16'd59770;
  localparam logic [ThrWidth-1:0]   ThresholdReset = 15'd26214;
  localparam logic [CoefWidth-1:0]  RatioReset    = 16'd6554;
  localparam logic [GainWidth-1:0]  GainUnity     = 20'h10000;

  typedef enum logic [RegIdxWidth-1:0] {
    RegAttack,
    RegRelease,
    RegTarget,
    RegSilence,
    RegIncrease,
    RegDecrease,
    RegThreshold,
    RegRatio
  } agc_reg_e;

  typedef struct packed {
    logic signed [SampleWidth-1:0] sample_in;
    logic                          frame_last;
  } agc_in_t;

  typedef struct packed {
    logic signed [SampleWidth-1:0] sample_out;
    logic                          frame_end;
  } agc_out_t;

  typedef enum logic [2:0] {
    MulNone,
    MulSampleGain,
    MulMagSq,
    MulPow,
    MulAvg,
    MulLim,
    MulGain
  } agc_mul_e;

  typedef enum logic [1:0] {
    AccHold,
    AccLoad,
    AccAdd
  } agc_acc_e;

  typedef enum logic [2:0] {
    WrNone,
    WrCapture,
    WrMag,
    WrPow,
    WrAvg,
    WrOut,
    WrGain
  } agc_wr_e;

  typedef enum logic [1:0] {
    JmpNext,
    JmpWaitIn,
    JmpEmit,
    JmpAlways
  } agc_jmp_e;

  typedef struct packed {
    agc_mul_e                mul;
    agc_acc_e                acc;
    agc_wr_e                 wr;
    agc_jmp_e                jmp;
    logic [StepCntWidth-1:0] target;
  } agc_uword_t;

  localparam logic [StepCntWidth-1:0] StepIdle    = 4'd0;
  localparam logic [StepCntWidth-1:0] StepMulGain = 4'd1;
  localparam logic [StepCntWidth-1:0] StepMag     = 4'd2;
  localparam logic [StepCntWidth-1:0] StepSquare  = 4'd3;
  localparam logic [StepCntWidth-1:0] StepPow     = 4'd4;
  localparam logic [StepCntWidth-1:0] StepAvgNew  = 4'd5;
  localparam logic [StepCntWidth-1:0] StepAvgOld  = 4'd6;
  localparam logic [StepCntWidth-1:0] StepAvgWr   = 4'd7;
  localparam logic [StepCntWidth-1:0] StepLimMul  = 4'd8;
  localparam logic [StepCntWidth-1:0] StepEmit    = 4'd9;
  localparam logic [StepCntWidth-1:0] StepGainMul = 4'd10;
  localparam logic [StepCntWidth-1:0] StepGainWr  = 4'd11;

  function automatic agc_uword_t ucode(logic [StepCntWidth-1:0] step);
    agc_uword_t uw;
    uw = '{MulNone, AccHold, WrNone, JmpAlways, StepIdle};
    unique case (step)
      StepIdle:    uw = '{MulNone,       AccHold, WrCapture, JmpWaitIn, StepIdle};
      StepMulGain: uw = '{MulSampleGain, AccLoad, WrNone,    JmpNext,   StepIdle};
      StepMag:     uw = '{MulNone,       AccHold, WrMag,     JmpNext,   StepIdle};
      StepSquare:  uw = '{MulMagSq,      AccLoad, WrNone,    JmpNext,   StepIdle};
      StepPow:     uw = '{MulNone,       AccHold, WrPow,     JmpNext,   StepIdle};
      StepAvgNew:  uw = '{MulPow,        AccLoad, WrNone,    JmpNext,   StepIdle};
      StepAvgOld:  uw = '{MulAvg,        AccAdd,  WrNone,    JmpNext,   StepIdle};
      StepAvgWr:   uw = '{MulNone,       AccHold, WrAvg,     JmpNext,   StepIdle};
      StepLimMul:  uw = '{MulLim,        AccLoad, WrNone,    JmpNext,   StepIdle};
      StepEmit:    uw = '{MulNone,       AccHold, WrOut,     JmpEmit,   StepIdle};
      StepGainMul: uw = '{MulGain,       AccLoad, WrNone,    JmpNext,   StepIdle};
      StepGainWr:  uw = '{MulNone,       AccHold, WrGain,    JmpAlways, StepIdle};
      default:     uw = '{MulNone,       AccHold, WrNone,    JmpAlways, StepIdle};
    endcase
    return uw;
  endfunction

endpackage

// File: sv/audio_automatic_gain_control.sv
// channel   direction  handshake                   beat
// input     in         in_valid_i / in_ready_o     agc_pkg::agc_in_t on in_data_i
// output    out        out_valid_o / out_ready_i   agc_pkg::agc_out_t on out_data_o
// config    in         psel / penable / pready     32-bit register write, paddr = 4 * index
//
// a beat passes from its accept through the microcode steps to the output register;
// a beat that closes a frame also runs the gain update steps before the next beat is taken
// every multiply goes through one shared 33 x 21 multiplier, at most one per microcode step
// in_ready_o is high only at the idle step; a held result stalls the emit step,
// while the idle step still takes a new beat
// async active-low reset restores registers, gain and power state
module audio_automatic_gain_control (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  agc_pkg::agc_in_t                    in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output agc_pkg::agc_out_t                   out_data_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [agc_pkg::AddrWidth-1:0]       paddr,
  input  logic [agc_pkg::DataWidth-1:0]       pwdata,
  output logic [agc_pkg::DataWidth-1:0]       prdata,
  output logic                                pready
);

  localparam int W        = agc_pkg::SampleWidth;
  localparam int MagW     = agc_pkg::MagWidth;
  localparam int ProdW    = agc_pkg::ProdWidth;
  localparam int AccW     = agc_pkg::AccWidth;
  localparam int GainW    = agc_pkg::GainWidth;
  localparam int PowW     = agc_pkg::PowWidth;
  localparam int MulAW    = agc_pkg::MulAWidth;
  localparam int MulBW    = agc_pkg::MulBWidth;
  localparam int StepW    = agc_pkg::StepCntWidth;
  localparam int PwShift  = 2 * W - 30;
  localparam int PwRsh    = (PwShift > 0) ? PwShift : 0;
  localparam int PwLsh    = (PwShift < 0) ? -PwShift : 0;
  localparam int ThrRsh   = (W < 16) ? 16 - W : 0;
  localparam int ThrLsh   = (W > 16) ? W - 16 : 0;
  localparam logic [AccW-1:0] PwRound  = (64'd1 << PwRsh) >> 1;
  localparam logic [31:0]     ThrRound = (32'd1 << ThrRsh) >> 1;
  localparam logic [AccW-1:0] HalfLsb  = 64'd32768;
  localparam logic [MagW:0]   PosLimit = (MagW+1)'((64'd1 << (W - 1)) - 64'd1);
  localparam logic [MagW:0]   NegLimit = (MagW+1)'(64'd1 << (W - 1));

  // configuration registers
  logic [agc_pkg::CoefWidth-1:0]  attack_q, release_q, decrease_q, ratio_q;
  logic [PowW-1:0]                target_q, silence_q;
  logic [agc_pkg::GstepWidth-1:0] increase_q;
  logic [agc_pkg::ThrWidth-1:0]   threshold_q;
  logic                           cfg_we;
  agc_pkg::agc_reg_e              cfg_idx;

  // sequencer and state
  logic [StepW-1:0]    step_q, step_d;
  agc_pkg::agc_uword_t uw;
  logic                out_valid_q, out_valid_d;
  logic                out_busy, emit;
  logic [GainW-1:0]    gain_q, gain_d, gain_before_q, gain_before_d;
  logic [PowW-1:0]     avg_q, avg_d, peak_q, peak_d;

  // datapath payload
  logic signed [W-1:0]    sample_q, sample_d;
  logic                   last_q, last_d;
  logic signed [AccW-1:0] acc_q, acc_d;
  logic                   neg_q, neg_d;
  logic [MagW-1:0]        mag_q, mag_d, exc_q, exc_d;
  logic                   over_q, over_d;
  logic [PowW-1:0]        pw_q, pw_d;
  logic                   att_q, att_d;
  agc_pkg::agc_out_t      out_q, out_d;

  // combinational datapath
  logic [agc_pkg::CoefWidth-1:0] coef_sel;
  logic signed [MulAW-1:0]       mul_a;
  logic signed [MulBW-1:0]       mul_b;
  logic signed [MulAW+MulBW-1:0] mul_p;
  logic signed [AccW-1:0]        p_full;
  logic [ProdW-1:0]              p_abs;
  logic [AccW-1:0]               pw_wide, rnd;
  logic [31:0]                   thr_wide;
  logic [MagW-1:0]               thr_s, lim_add;
  logic [MagW:0]                 mag_lim, y_mag, y_full;
  logic [GainW-1:0]              g_step, g_sel;
  logic [GainW:0]                g_sum;

  assign pready  = 1'b1;
  assign cfg_we  = psel & penable & pwrite;
  assign cfg_idx = agc_pkg::agc_reg_e'(paddr[agc_pkg::AddrWidth-1:2]);

  always_comb begin
    unique case (cfg_idx)
      agc_pkg::RegAttack:    prdata = 32'(attack_q);
      agc_pkg::RegRelease:   prdata = 32'(release_q);
      agc_pkg::RegTarget:    prdata = target_q;
      agc_pkg::RegSilence:   prdata = silence_q;
      agc_pkg::RegIncrease:  prdata = 32'(increase_q);
      agc_pkg::RegDecrease:  prdata = 32'(decrease_q);
      agc_pkg::RegThreshold: prdata = 32'(threshold_q);
      agc_pkg::RegRatio:     prdata = 32'(ratio_q);
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attack_q    <= agc_pkg::AttackReset;
      release_q   <= agc_pkg::ReleaseReset;
      target_q    <= agc_pkg::TargetReset;
      silence_q   <= agc_pkg::SilenceReset;
      increase_q  <= agc_pkg::IncreaseReset;
      decrease_q  <= agc_pkg::DecreaseReset;
      threshold_q <= agc_pkg::ThresholdReset;
      ratio_q     <= agc_pkg::RatioReset;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        agc_pkg::RegAttack:    attack_q    <= pwdata[agc_pkg::CoefWidth-1:0];
        agc_pkg::RegRelease:   release_q   <= pwdata[agc_pkg::CoefWidth-1:0];
        agc_pkg::RegTarget:    target_q    <= pwdata[PowW-1:0];
        agc_pkg::RegSilence:   silence_q   <= pwdata[PowW-1:0];
        agc_pkg::RegIncrease:  increase_q  <= pwdata[agc_pkg::GstepWidth-1:0];
        agc_pkg::RegDecrease:  decrease_q  <= pwdata[agc_pkg::CoefWidth-1:0];
        agc_pkg::RegThreshold: threshold_q <= pwdata[agc_pkg::ThrWidth-1:0];
        agc_pkg::RegRatio:     ratio_q     <= pwdata[agc_pkg::CoefWidth-1:0];
      endcase
    end
  end

  // control word fetch and step counter
  assign uw         = agc_pkg::ucode(step_q);
  assign in_ready_o = (step_q == agc_pkg::StepIdle);
  assign out_busy   = out_valid_q & ~out_ready_i;
  assign emit       = (uw.wr == agc_pkg::WrOut) & ~out_busy;

  always_comb begin
    step_d = step_q + StepW'(1);
    unique case (uw.jmp)
      agc_pkg::JmpNext:   step_d = step_q + StepW'(1);
      agc_pkg::JmpWaitIn: step_d = in_valid_i ? step_q + StepW'(1) : step_q;
      agc_pkg::JmpEmit: begin
        if (out_busy) begin
          step_d = step_q;
        end else if (!last_q) begin
          step_d = uw.target;
        end
      end
      agc_pkg::JmpAlways: step_d = uw.target;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // shared multiplier
  assign coef_sel = att_q ? attack_q : release_q;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (uw.mul)
      agc_pkg::MulSampleGain: begin
        mul_a = MulAW'(gain_q);
        mul_b = MulBW'(sample_q);
      end
      agc_pkg::MulMagSq: begin
        mul_a = MulAW'(mag_q);
        mul_b = MulBW'(mag_q);
      end
      agc_pkg::MulPow: begin
        mul_a = MulAW'(pw_q);
        mul_b = MulBW'(17'h10000 - {1'b0, coef_sel});
      end
      agc_pkg::MulAvg: begin
        mul_a = MulAW'(avg_q);
        mul_b = MulBW'(coef_sel);
      end
      agc_pkg::MulLim: begin
        mul_a = MulAW'(exc_q);
        mul_b = MulBW'(ratio_q);
      end
      agc_pkg::MulGain: begin
        mul_a = MulAW'(gain_q);
        mul_b = (peak_q > target_q) ? MulBW'(decrease_q) : MulBW'(increase_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_comb begin
    case (uw.acc)
      agc_pkg::AccLoad: acc_d = AccW'(mul_p);
      agc_pkg::AccAdd:  acc_d = acc_q + AccW'(mul_p);
      default:          acc_d = acc_q;
    endcase
  end

  // fixed datapath pieces read from the accumulator and the state registers
  assign rnd      = $unsigned(acc_q) + HalfLsb;
  assign p_full   = (acc_q + $signed(HalfLsb)) >>> 16;
  assign p_abs    = p_full[ProdW-1] ? ProdW'(-p_full) : p_full[ProdW-1:0];
  assign pw_wide  = (($unsigned(acc_q) + PwRound) >> PwRsh) << PwLsh;
  assign thr_wide = ((32'(threshold_q) + ThrRound) >> ThrRsh) << ThrLsh;
  assign thr_s    = thr_wide[MagW-1:0];
  assign lim_add  = rnd[MagW+15:16];
  assign mag_lim  = over_q ? {1'b0, thr_s} + {1'b0, lim_add} : {1'b0, mag_q};
  assign g_step   = (|rnd[AccW-1:GainW+16]) ? '1 : rnd[GainW+15:16];
  assign g_sel    = (peak_q > silence_q) ? g_step : agc_pkg::GainUnity;
  assign g_sum    = {1'b0, g_sel} + {1'b0, gain_before_q} + (GainW+1)'(1);

  always_comb begin
    if (neg_q) begin
      y_mag = (mag_lim > NegLimit) ? NegLimit : mag_lim;
    end else begin
      y_mag = (mag_lim > PosLimit) ? PosLimit : mag_lim;
    end
    y_full = neg_q ? -y_mag : y_mag;
  end

  always_comb begin
    sample_d      = sample_q;
    last_d        = last_q;
    neg_d         = neg_q;
    mag_d         = mag_q;
    exc_d         = exc_q;
    over_d        = over_q;
    pw_d          = pw_q;
    att_d         = att_q;
    out_d         = out_q;
    avg_d         = avg_q;
    peak_d        = peak_q;
    gain_d        = gain_q;
    gain_before_d = gain_before_q;
    case (uw.wr)
      agc_pkg::WrCapture: begin
        sample_d = in_data_i.sample_in;
        last_d   = in_data_i.frame_last;
      end
      agc_pkg::WrMag: begin
        neg_d = p_full[ProdW-1];
        mag_d = p_abs[MagW-1:0];
      end
      agc_pkg::WrPow: begin
        pw_d  = (|pw_wide[AccW-1:PowW]) ? '1 : pw_wide[PowW-1:0];
        att_d = pw_d > avg_q;
      end
      agc_pkg::WrAvg: begin
        avg_d  = rnd[PowW+15:16];
        peak_d = (avg_d > peak_q) ? avg_d : peak_q;
        over_d = mag_q > thr_s;
        exc_d  = mag_q - thr_s;
      end
      agc_pkg::WrOut: begin
        if (emit) begin
          out_d.sample_out = y_full[W-1:0];
          out_d.frame_end  = last_q;
        end
      end
      agc_pkg::WrGain: begin
        gain_d        = g_sum[GainW:1];
        gain_before_d = g_sum[GainW:1];
        peak_d        = '0;
      end
      default: begin
        out_d = out_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q        <= agc_pkg::StepIdle;
      out_valid_q   <= 1'b0;
      gain_q        <= agc_pkg::GainUnity;
      gain_before_q <= '0;
      avg_q         <= '0;
      peak_q        <= '0;
    end else begin
      step_q        <= step_d;
      out_valid_q   <= out_valid_d;
      gain_q        <= gain_d;
      gain_before_q <= gain_before_d;
      avg_q         <= avg_d;
      peak_q        <= peak_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sample_q <= sample_d;
    last_q   <= last_d;
    acc_q    <= acc_d;
    neg_q    <= neg_d;
    mag_q    <= mag_d;
    exc_q    <= exc_d;
    over_q   <= over_d;
    pw_q     <= pw_d;
    att_q    <= att_d;
    out_q    <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: sv/agc_checker.sv
module agc_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input agc_pkg::agc_out_t out_data_o,
  input logic              pready
);

  // a held result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped before it was taken");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("result changed while stalled");

  // one beat at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken again while a beat is in flight");

  // a result never appears in the cycle after its beat is accepted
  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !$rose(out_valid_o))
    else $error("result appeared too early");

  a_pready_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready)
    else $error("register port stalled");

endmodule

bind audio_automatic_gain_control agc_checker u_agc_checker (.*);
